// ===== sv/icpc_pkg.sv =====
`timescale 1ns / 1ps

package icpc_pkg;

  localparam int CP_W    = 21;
  localparam int COUNT_W = 11;
  localparam int INDEX_W = 10;
  localparam int OP_W    = 2;
  localparam int CFG_W   = 1;

  localparam logic [OP_W-1:0] OP_QUERY      = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_START = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD_CONT  = 2'd2;

  localparam logic [CFG_W-1:0] REG_START_COUNT = 1'b0;
  localparam logic [CFG_W-1:0] REG_CONT_COUNT  = 1'b1;

  localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
  localparam logic [CP_W-1:0] CH_DOLLAR   = 21'h000024;
  localparam logic [CP_W-1:0] CH_UNDER    = 21'h00005F;
  localparam logic [CP_W-1:0] CH_DIGIT_0  = 21'h000030;
  localparam logic [CP_W-1:0] CH_DIGIT_9  = 21'h000039;
  localparam logic [CP_W-1:0] CH_UPPER_A  = 21'h000041;
  localparam logic [CP_W-1:0] CH_UPPER_Z  = 21'h00005A;
  localparam logic [CP_W-1:0] CH_LOWER_A  = 21'h000061;
  localparam logic [CP_W-1:0] CH_LOWER_Z  = 21'h00007A;

  typedef struct packed {
    logic [CP_W-1:0] low;
    logic [CP_W-1:0] high;
  } range_t;

  localparam int RANGE_W = $bits(range_t);

  function automatic logic is_fast_accept(logic [CP_W-1:0] c, logic first);
    logic letter;
    logic digit;
    letter = ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
             ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
    digit  = (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
    if (first) begin
      return (c == CH_DOLLAR) || (c == CH_UNDER) || letter;
    end
    return (c == CH_DOLLAR) || letter || digit;
  endfunction

  function automatic logic is_rejected(logic [CP_W-1:0] c);
    return (c > CP_MAX) || ((c >= SURR_LO) && (c <= SURR_HI));
  endfunction

endpackage

// ===== sv/icpc_ram.sv =====
`timescale 1ns / 1ps

module icpc_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/identifier_code_point_check.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake             payload
// in        into       in_valid / in_stall   op, cp_value, is_first, entry_index,
//                                            range_low, range_high
// out       out of     out_valid / out_stall is_valid
// cfg       into       cfg_we                cfg_index, cfg_data
//
// A load writes its range memory at the transfer. A query answered by the ASCII fast path
// or rejected as out of range or surrogate is decided at the transfer, with no search; a
// table query searches the clamped count of ranges: the transfer, one range memory read
// per search step and the low-end check.
// Reset clears the counts, the controller and the output; the range memories keep
// their contents and must be loaded before use.
// in_stall is high while a query is searching or its answer waits for the output
// register; a held result does not block a new transfer into the block.

module identifier_code_point_check
  import icpc_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    op,
  input  logic [CP_W-1:0]    cp_value,
  input  logic               is_first,
  input  logic [INDEX_W-1:0] entry_index,
  input  logic [CP_W-1:0]    range_low,
  input  logic [CP_W-1:0]    range_high,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               is_valid,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_index,
  input  logic [COUNT_W-1:0] cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_CHECK  = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]         state, state_next;
  logic [COUNT_W-1:0] start_count, cont_count;
  logic [CP_W-1:0]    cp_q;
  logic               first_q;
  logic [CW-1:0]      n_q, lo, len;
  logic [CW-1:0]      lo_next, len_next;
  logic               res, res_next;
  logic               out_next_valid;

  logic               in_xfer;
  logic [CW-1:0]      n_start, n_cont, n_sel;
  logic [CW-1:0]      half, mid;
  logic               go_right;
  logic               slot_free;
  logic               post;
  logic               post_bit;
  logic [AW-1:0]      raddr;
  logic               load_ok;
  range_t             wdata;
  range_t             start_rd, cont_rd, rd;

  function automatic logic [CW-1:0] clamp_count(logic [COUNT_W-1:0] c);
    if (32'(c) > TABLE_DEPTH) begin
      return CW'(TABLE_DEPTH);
    end
    return CW'(c);
  endfunction

  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  assign n_start = clamp_count(start_count);
  assign n_cont  = clamp_count(cont_count);
  assign n_sel   = is_first ? n_start : n_cont;

  assign half     = len >> 1;
  assign mid      = lo + half;
  assign rd       = first_q ? start_rd : cont_rd;
  assign go_right = rd.high < cp_q;

  assign load_ok    = 32'(entry_index) < TABLE_DEPTH;
  assign wdata.low  = range_low;
  assign wdata.high = range_high;

  always_comb begin
    state_next = state;
    lo_next    = lo;
    len_next   = len;
    post       = 1'b0;
    post_bit   = 1'b0;
    raddr      = '0;
    unique case (state)
      S_IDLE: begin
        lo_next  = '0;
        len_next = n_sel;
        raddr    = AW'(n_sel >> 1);
        if (in_xfer && (op == OP_QUERY)) begin
          if (is_fast_accept(cp_value, is_first)) begin
            post     = 1'b1;
            post_bit = 1'b1;
          end else if (is_rejected(cp_value) || (n_sel == '0)) begin
            post = 1'b1;
          end else begin
            state_next = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (go_right) begin
          lo_next  = mid + CW'(1);
          len_next = len - half - CW'(1);
        end else begin
          len_next = half;
        end
        if (len_next != '0) begin
          raddr = AW'(lo_next + (len_next >> 1));
        end else begin
          raddr = AW'(lo_next);
          if (lo_next < n_q) begin
            state_next = S_CHECK;
          end else begin
            post = 1'b1;
          end
        end
      end
      S_CHECK: begin
        post     = 1'b1;
        post_bit = cp_q >= rd.low;
      end
      S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (post) begin
      state_next = slot_free ? S_IDLE : S_DONE;
    end
  end

  always_comb begin
    out_next_valid = out_valid && out_stall;
    res_next       = res;
    if (post) begin
      res_next = post_bit;
    end
    if ((post || (state == S_DONE)) && slot_free) begin
      out_next_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      start_count <= '0;
      cont_count  <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_next_valid;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_START_COUNT: start_count <= cfg_data;
          REG_CONT_COUNT:  cont_count  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    lo  <= lo_next;
    len <= len_next;
    res <= res_next;
    if (in_xfer) begin
      cp_q    <= cp_value;
      first_q <= is_first;
      n_q     <= n_sel;
    end
    if ((post || (state == S_DONE)) && slot_free) begin
      is_valid <= res_next;
    end
  end

  icpc_ram #(
    .WIDTH (RANGE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_start_ram (
    .clk   (clk),
    .we    (in_xfer && (op == OP_LOAD_START) && load_ok),
    .waddr (AW'(entry_index)),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (start_rd)
  );

  icpc_ram #(
    .WIDTH (RANGE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_cont_ram (
    .clk   (clk),
    .we    (in_xfer && (op == OP_LOAD_CONT) && load_ok),
    .waddr (AW'(entry_index)),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (cont_rd)
  );

endmodule

// ===== sv/icpc_checker.sv =====
`timescale 1ns / 1ps

module icpc_checker
  import icpc_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input logic [OP_W-1:0] op,
  input logic [CP_W-1:0] cp_value,
  input logic            out_valid,
  input logic            out_stall,
  input logic            is_valid
);

  logic in_xfer;
  logic slot_free;

  assign in_xfer   = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(is_valid))
    else $error("held result changed");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (op != OP_QUERY) |=> !$rose(out_valid))
    else $error("result after a load transfer");

  a_dollar_fast: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (op == OP_QUERY) && (cp_value == CH_DOLLAR) && slot_free
    |=> out_valid && is_valid)
    else $error("dollar sign not accepted at once");

  a_range_reject: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (op == OP_QUERY) && (cp_value > CP_MAX) && slot_free
    |=> out_valid && !is_valid)
    else $error("code point above maximum not rejected at once");

endmodule

bind identifier_code_point_check icpc_checker u_icpc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .op         (op),
  .cp_value   (cp_value),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .is_valid   (is_valid)
);

// ===== test/tb_identifier_code_point_check.sv =====
`timescale 1ns / 1ps

module tb_identifier_code_point_check;
  import icpc_pkg::*;

  localparam int DEPTH = 1024;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_QUERIES = 44;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [CP_W-1:0]    cp;
    logic               first;
    logic [INDEX_W-1:0] idx;
    logic [CP_W-1:0]    lo;
    logic [CP_W-1:0]    hi;
    logic               known;
    logic               answer;
  } stim_row_t;

  typedef struct packed {
    logic [COUNT_W-1:0] start_count;
    logic [COUNT_W-1:0] cont_count;
    logic               reload;
    logic               sorted;
  } phase_t;

  localparam int NUM_DIRECTED = 24;
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{OP_QUERY, CH_DOLLAR, 1'b1, 10'd0, 21'd0, 21'd0, 1'b1, 1'b1},
    '{OP_QUERY, CH_UNDER, 1'b1, 10'd0, 21'd0, 21'd0, 1'b1, 1'b1},
    '{OP_QUERY, CH_UNDER, 1'b0, 10'd0, 21'd0, 21'd0, 1'b1, 1'b0},
    '{OP_QUERY, CH_UPPER_A, 1'b1, 10'd0, 21'd0, 21'd0, 1'b1, 1'b1},
    '{OP_QUERY, CH_UPPER_Z, 1'b0, 10'd0, 21'd0, 21'd0, 1'b1, 1'b1},
    '{OP_QUERY, CH_LOWER_A, 1'b1, 10'd0, 21'd0, 21'd0, 1'b1, 1'b1},
    '{OP_QUERY, CH_LOWER_Z, 1'b0, 10'd0, 21'd0, 21'd0, 1'b1, 1'b1},
    '{OP_QUERY, CH_DIGIT_0, 1'b1, 10'd0, 21'd0, 21'd0, 1'b1, 1'b0},
    '{OP_QUERY, CH_DIGIT_9, 1'b0, 10'd0, 21'd0, 21'd0, 1'b1, 1'b1},
    '{OP_QUERY, 21'h000040, 1'b1, 10'd0, 21'd0, 21'd0, 1'b1, 1'b0},
    '{OP_QUERY, 21'h000060, 1'b0, 10'd0, 21'd0, 21'd0, 1'b1, 1'b0},
    '{OP_QUERY, 21'h000000, 1'b0, 10'd0, 21'd0, 21'd0, 1'b1, 1'b0},
    '{OP_QUERY, CP_MAX, 1'b1, 10'd0, 21'd0, 21'd0, 1'b1, 1'b0},
    '{OP_QUERY, 21'h110000, 1'b0, 10'd0, 21'd0, 21'd0, 1'b1, 1'b0},
    '{OP_QUERY, 21'h1FFFFF, 1'b1, 10'd0, 21'd0, 21'd0, 1'b1, 1'b0},
    '{OP_QUERY, SURR_LO, 1'b1, 10'd0, 21'd0, 21'd0, 1'b1, 1'b0},
    '{OP_QUERY, SURR_HI, 1'b0, 10'd0, 21'd0, 21'd0, 1'b1, 1'b0},
    '{OP_UNUSED, 21'h1FFFFF, 1'b1, 10'h3FF, 21'h1FFFFF, 21'h1FFFFF, 1'b0, 1'b0},
    '{OP_LOAD_START, 21'd0, 1'b0, 10'd0, 21'd0, CP_MAX, 1'b0, 1'b0},
    '{OP_LOAD_START, 21'd0, 1'b0, 10'd1023, CP_MAX, CP_MAX, 1'b0, 1'b0},
    '{OP_LOAD_CONT, 21'd0, 1'b0, 10'd0, 21'd0, 21'd0, 1'b0, 1'b0},
    '{OP_LOAD_CONT, 21'd0, 1'b0, 10'd1023, 21'h100000, CP_MAX, 1'b0, 1'b0},
    '{OP_QUERY, 21'h00E000, 1'b1, 10'd0, 21'd0, 21'd0, 1'b1, 1'b0},
    '{OP_QUERY, 21'h00D7FF, 1'b0, 10'd0, 21'd0, 21'd0, 1'b1, 1'b0}
  };

  localparam int NUM_PHASES = 9;
  localparam phase_t PHASES [NUM_PHASES] = '{
    '{11'd1, 11'd1, 1'b0, 1'b1},
    '{11'd2, 11'd3, 1'b1, 1'b1},
    '{11'd16, 11'd7, 1'b1, 1'b1},
    '{11'd64, 11'd64, 1'b1, 1'b1},
    '{11'd63, 11'd40, 1'b0, 1'b1},
    '{11'd64, 11'd0, 1'b0, 1'b1},
    '{11'd0, 11'd1, 1'b0, 1'b1},
    '{11'd32, 11'd32, 1'b1, 1'b0},
    '{11'd5, 11'd40, 1'b1, 1'b1}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [OP_W-1:0]    op = OP_QUERY;
  logic [CP_W-1:0]    cp_value = '0;
  logic               is_first = 1'b0;
  logic [INDEX_W-1:0] entry_index = '0;
  logic [CP_W-1:0]    range_low = '0;
  logic [CP_W-1:0]    range_high = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               is_valid;
  logic               cfg_we = 1'b0;
  logic [CFG_W-1:0]   cfg_index = REG_START_COUNT;
  logic [COUNT_W-1:0] cfg_data = '0;

  logic typed_known = 1'b0;
  logic typed_answer = 1'b0;

  range_t             start_tab [DEPTH];
  range_t             cont_tab [DEPTH];
  logic [COUNT_W-1:0] start_count = '0;
  logic [COUNT_W-1:0] cont_count = '0;
  logic               pending_answers [$];

  int   errors = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   quiet_cycles = 0;
  int   layout_start = DEPTH;
  int   layout_cont = DEPTH;
  logic sorted_now = 1'b1;

  identifier_code_point_check #(.TABLE_DEPTH(DEPTH)) uut (.*);

  always #6 clk = ~clk;

  function automatic int used_ranges(logic [COUNT_W-1:0] count);
    return (count > DEPTH) ? DEPTH : int'(count);
  endfunction

  function automatic logic predict_valid(logic [CP_W-1:0] c, logic first);
    int     n;
    int     lo;
    int     len;
    int     half;
    int     mid;
    range_t entry;
    logic   letter;
    logic   digit;
    letter = (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    digit = c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
    if (first && (c == CH_DOLLAR || c == CH_UNDER || letter)) begin
      return 1'b1;
    end
    if (!first && (c == CH_DOLLAR || letter || digit)) begin
      return 1'b1;
    end
    if (c > CP_MAX || (c >= SURR_LO && c <= SURR_HI)) begin
      return 1'b0;
    end
    n = used_ranges(first ? start_count : cont_count);
    lo = 0;
    len = n;
    while (len > 0) begin
      half = len / 2;
      mid = lo + half;
      entry = first ? start_tab[mid] : cont_tab[mid];
      if (entry.high < c) begin
        lo = mid + 1;
        len = len - half - 1;
      end else begin
        len = half;
      end
    end
    if (lo >= n) begin
      return 1'b0;
    end
    entry = first ? start_tab[lo] : cont_tab[lo];
    return c >= entry.low;
  endfunction

  function automatic range_t make_range(int slot, int span, logic sorted);
    range_t r;
    int     stride;
    if (!sorted) begin
      r.low = CP_W'($urandom_range(0, CP_MAX));
      r.high = CP_W'($urandom_range(0, CP_MAX));
      return r;
    end
    stride = (int'(CP_MAX) + 1) / span;
    r.low = CP_W'(slot * stride + $urandom_range(0, stride / 2));
    r.high = CP_W'(r.low + $urandom_range(0, stride / 2 - 1));
    return r;
  endfunction

  function automatic logic [CP_W-1:0] pick_point(logic first);
    int     roll;
    int     n;
    int     slot;
    range_t entry;
    roll = $urandom_range(0, 99);
    n = used_ranges(first ? start_count : cont_count);
    if (roll < 15) begin
      return CP_W'($urandom_range(0, 127));
    end
    if (roll < 27) begin
      case ($urandom_range(0, 7))
        0: return CP_MAX;
        1: return CP_W'(CP_MAX + 1);
        2: return CP_W'($urandom_range(int'(CP_MAX) + 1, 21'h1FFFFF));
        3: return CP_W'(SURR_LO - 1);
        4: return SURR_LO;
        5: return CP_W'($urandom_range(SURR_LO, SURR_HI));
        6: return SURR_HI;
        default: return CP_W'(SURR_HI + 1);
      endcase
    end
    if (roll < 87 && n > 0) begin
      slot = $urandom_range(0, n - 1);
      entry = first ? start_tab[slot] : cont_tab[slot];
      case ($urandom_range(0, 4))
        0: return CP_W'(entry.low - 1);
        1: return entry.low;
        2: return entry.high;
        3: return CP_W'(entry.high + 1);
        default: return CP_W'($urandom_range(entry.low, entry.high));
      endcase
    end
    return CP_W'($urandom());
  endfunction

  // hold the payload until the transfer completes
  task automatic send(input stim_row_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= r.op;
    cp_value <= r.cp;
    is_first <= r.first;
    entry_index <= r.idx;
    range_low <= r.lo;
    range_high <= r.hi;
    typed_known <= r.known;
    typed_answer <= r.answer;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_load(input logic [OP_W-1:0] kind, input int slot, input range_t r);
    send(stim_row_t'{kind, 21'($urandom()), 1'($urandom()), slot[INDEX_W-1:0],
                     r.low, r.high, 1'b0, 1'b0});
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      case (op)
        OP_QUERY: begin
          pending_answers.push_back(typed_known ? typed_answer
                                                : predict_valid(cp_value, is_first));
        end
        OP_LOAD_START: start_tab[entry_index] = '{low: range_low, high: range_high};
        OP_LOAD_CONT: cont_tab[entry_index] = '{low: range_low, high: range_high};
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    logic want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual is_valid=%0b", $time,
                 is_valid);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (is_valid !== want) begin
          $display("%0t: is_valid mismatch, expected %0b, actual %0b", $time, want,
                   is_valid);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    phase_t ph;
    int     ns;
    int     nc;
    int     queries;
    int     roll;
    int     slot;
    int     mode;
    logic   first;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED[i]) begin
      send(DIRECTED[i]);
    end
    drain();
    for (int p = 0; p < NUM_PHASES; p++) begin
      ph = PHASES[p];
      mode = (p + 1) % 4;
      idle_pct = (mode == 1) ? 45 : (mode == 3) ? 9 : 0;
      stall_pct = (mode == 2) ? 45 : (mode == 3) ? 9 : 0;
      cfg_we <= 1'b1;
      cfg_index <= REG_START_COUNT;
      cfg_data <= ph.start_count;
      @(posedge clk);
      cfg_index <= REG_CONT_COUNT;
      cfg_data <= ph.cont_count;
      @(posedge clk);
      cfg_we <= 1'b0;
      start_count = ph.start_count;
      cont_count = ph.cont_count;
      sorted_now = ph.sorted;
      ns = used_ranges(ph.start_count);
      nc = used_ranges(ph.cont_count);
      if (ph.reload) begin
        layout_start = ns;
        layout_cont = nc;
        for (int i = 0; i < ns; i++) begin
          send_load(OP_LOAD_START, i, make_range(i, layout_start, sorted_now));
        end
        for (int i = 0; i < nc; i++) begin
          send_load(OP_LOAD_CONT, i, make_range(i, layout_cont, sorted_now));
        end
      end
      queries = 0;
      while (queries < PHASE_QUERIES) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          slot = $urandom_range(0, layout_start - 1);
          send_load(OP_LOAD_START, slot, make_range(slot, layout_start, sorted_now));
        end else if (roll < 10) begin
          slot = $urandom_range(0, layout_cont - 1);
          send_load(OP_LOAD_CONT, slot, make_range(slot, layout_cont, sorted_now));
        end else if (roll < 13) begin
          send(stim_row_t'{OP_UNUSED, 21'($urandom()), 1'($urandom()), 10'($urandom()),
                           21'($urandom()), 21'($urandom()), 1'b0, 1'b0});
        end else begin
          first = 1'($urandom_range(0, 1));
          send(stim_row_t'{OP_QUERY, pick_point(first), first, 10'($urandom()),
                           21'($urandom()), 21'($urandom()), 1'b0, 1'b0});
          queries++;
        end
      end
      drain();
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/icpc_pkg.sv
sv/icpc_ram.sv
sv/identifier_code_point_check.sv
sv/icpc_checker.sv
test/tb_identifier_code_point_check.sv
